// ----- hdl/emgtd_pkg.sv -----
package emgtd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int DZ_W     = 15;
    localparam int THR_W    = 16;

    typedef enum logic [0:0] {
        REG_DEADZONE = 1'd0,
        REG_TURN_THR = 1'd1
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    // one divide job for the shared divider
    typedef struct packed {
        logic        start;
        logic        neg;
        logic [31:0] dividend;
        logic [13:0] divisor;
    } div_req_t;

endpackage

// ----- hdl/emgtd_lane.sv -----
module emgtd_lane #(
    parameter int LAG   = 2,
    parameter int SUM_W = 27,
    parameter int CNT_W = 11
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   step,
    input  logic                                   clear,
    input  logic                                   full_hist,
    input  logic signed [emgtd_pkg::SAMPLE_W-1:0]  sample,
    input  logic [emgtd_pkg::DZ_W-1:0]             deadzone,
    input  logic [emgtd_pkg::THR_W-1:0]            threshold,
    output logic signed [SUM_W-1:0]                sample_sum,
    output logic [SUM_W-1:0]                       length_sum,
    output logic [CNT_W-1:0]                       cross_count,
    output logic [CNT_W-1:0]                       turn_count
);
    localparam int DEPTH = 2 * LAG;

    logic signed [emgtd_pkg::SAMPLE_W-1:0] hist_reg [DEPTH];
    logic signed [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0]        len_reg;
    logic [CNT_W-1:0]        cross_reg;
    logic [CNT_W-1:0]        turn_reg;

    logic signed [16:0] fst, mid, lst, dz;
    logic [16:0] d_fm, d_ml;
    logic same, in_dz, extremum, big;

    always_comb
    begin
        fst  = 17'(hist_reg[DEPTH-1]);
        mid  = 17'(hist_reg[LAG-1]);
        lst  = 17'(sample);
        dz   = $signed({2'b00, deadzone});
        d_fm = (mid > fst) ? 17'(mid - fst) : 17'(fst - mid);
        d_ml = (mid > lst) ? 17'(mid - lst) : 17'(lst - mid);
        same = (mid >= 0 && fst >= 0) || (mid <= 0 && fst <= 0);
        in_dz = (mid < dz) && (mid > -dz) && (fst < dz) && (fst > -dz);
        extremum = (mid > fst && mid > lst) || (mid < fst && mid < lst);
        big = (d_fm > 17'(threshold)) || (d_ml > 17'(threshold));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
                hist_reg[k] <= '0;
            sum_reg   <= '0;
            len_reg   <= '0;
            cross_reg <= '0;
            turn_reg  <= '0;
        end
        else if (clear)
        begin
            sum_reg   <= '0;
            len_reg   <= '0;
            cross_reg <= '0;
            turn_reg  <= '0;
        end
        else if (step)
        begin
            sum_reg <= sum_reg + SUM_W'(sample);
            if (full_hist)
            begin
                len_reg <= len_reg + SUM_W'(d_fm);
                if (!same && !in_dz)
                    cross_reg <= cross_reg + 1'b1;
                if (extremum && big)
                    turn_reg <= turn_reg + 1'b1;
            end
            hist_reg[0] <= sample;
            for (int k = 1; k < DEPTH; k++)
                hist_reg[k] <= hist_reg[k-1];
        end
    end

    assign sample_sum  = sum_reg;
    assign length_sum  = len_reg;
    assign cross_count = cross_reg;
    assign turn_count  = turn_reg;
endmodule

// ----- hdl/emgtd_div.sv -----
// Restoring divider, one quotient bit per cycle.
module emgtd_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  emgtd_pkg::div_req_t   req,
    output logic                  done,
    output logic [31:0]           quotient
);
    logic [31:0] q_reg;
    logic [13:0] rem_reg;
    logic [13:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        neg_reg;
    logic [14:0] trial;

    assign trial = {rem_reg, q_reg[31]} - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg   <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
            neg_reg <= req.neg;
        end
        else if (busy_reg)
        begin
            if (!trial[14])
            begin
                rem_reg <= trial[13:0];
                q_reg   <= {q_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[12:0], q_reg[31]};
                q_reg   <= {q_reg[30:0], 1'b0};
            end
        end
    end

    assign quotient = neg_reg ? (~q_reg + 32'd1) : q_reg;
endmodule

// ----- hdl/emg_time_domain_features_unit.sv -----
// Four-channel EMG time-domain feature unit. Every channel has its own lane that
// updates sum, waveform length, zero crossings and turns in the cycle a sample
// vector is accepted, up to MAX_WINDOW samples per window; samples that do not
// close a window can be accepted back to back. The item that closes a window
// starts the merge stage: one shared divider forms the mean, waveform length,
// crossing rate and turn rate of each channel in turn (4 divides per channel),
// and the four results go out channel 0 first on m_axis, the channel index in
// tuser and channel 3 flagged in tlast. s_axis_tready is low from that item
// until the last result transaction.
module emg_time_domain_features_unit #(
    parameter int MAX_WINDOW = 1024,
    parameter int CHANNELS   = 4,
    parameter int LAG        = 2
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // sample_ch0 .. sample_ch(CHANNELS-1), 16 bits each
    input  logic [16*CHANNELS-1:0]    s_axis_tdata,
    input  logic                      s_axis_tlast,   // last_in_window
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // mean_value, waveform_length, zero_cross_rate, turn_rate
    output logic [63:0]               m_axis_tdata,
    output logic [1:0]                m_axis_tuser,   // channel
    output logic                      m_axis_tlast,   // last_result
    input  logic                      cfg_we,
    input  logic [0:0]                cfg_index,
    input  logic [15:0]               cfg_data
);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = 16 + CNT_W;
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [emgtd_pkg::DZ_W-1:0]  dz_reg;
    logic [emgtd_pkg::THR_W-1:0] thr_reg;
    logic [CNT_W-1:0]            count_reg;
    emgtd_pkg::state_t           state_reg, state_next;
    logic [CH_W-1:0]             ch_reg, ch_next;
    logic [1:0]                  feat_reg, feat_next;
    logic [15:0]                 res_reg [4];

    logic accept, step, clear, full_hist;
    logic signed [SUM_W-1:0] lane_sum   [CHANNELS];
    logic [SUM_W-1:0]        lane_len   [CHANNELS];
    logic [CNT_W-1:0]        lane_cross [CHANNELS];
    logic [CNT_W-1:0]        lane_turn  [CHANNELS];

    emgtd_pkg::div_req_t req;
    logic        div_done;
    logic [31:0] quot;
    logic        div_started_reg;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign step      = accept && (count_reg < CNT_W'(MAX_WINDOW));
    assign full_hist = count_reg >= CNT_W'(2 * LAG);
    assign clear     = (state_reg == emgtd_pkg::ST_EMIT) && m_axis_tready
                       && (ch_reg == CH_W'(CHANNELS - 1));

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        emgtd_lane #(.LAG(LAG), .SUM_W(SUM_W), .CNT_W(CNT_W)) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .step       (step),
            .clear      (clear),
            .full_hist  (full_hist),
            .sample     (s_axis_tdata[16*c +: 16]),
            .deadzone   (dz_reg),
            .threshold  (thr_reg),
            .sample_sum (lane_sum[c]),
            .length_sum (lane_len[c]),
            .cross_count(lane_cross[c]),
            .turn_count (lane_turn[c])
        );
    end

    // divide job for the current channel and feature
    logic signed [SUM_W-1:0] cur_sum;
    logic [SUM_W-1:0]        abs_sum;
    always_comb
    begin
        cur_sum      = lane_sum[ch_reg];
        abs_sum      = cur_sum[SUM_W-1] ? SUM_W'(-cur_sum) : SUM_W'(cur_sum);
        req.start    = (state_reg == emgtd_pkg::ST_DIV) && !div_started_reg;
        req.neg      = 1'b0;
        req.divisor  = 14'(count_reg);
        req.dividend = '0;
        unique case (feat_reg)
            2'd0:
            begin
                req.dividend = 32'(abs_sum);
                req.neg      = cur_sum[SUM_W-1];
            end
            2'd1:
            begin
                req.dividend = 32'(lane_len[ch_reg]);
                req.divisor  = 14'({count_reg, 1'b0});
            end
            2'd2: req.dividend = 32'({lane_cross[ch_reg], 16'd0});
            default: req.dividend = 32'({lane_turn[ch_reg], 16'd0});
        endcase
    end

    emgtd_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .done    (div_done),
        .quotient(quot)
    );

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        feat_next  = feat_reg;
        unique case (state_reg)
            emgtd_pkg::ST_IDLE:
                if (accept && s_axis_tlast)
                    state_next = emgtd_pkg::ST_DIV;
            emgtd_pkg::ST_DIV:
                if (div_done)
                begin
                    feat_next = feat_reg + 1'b1;
                    if (feat_reg == 2'd3)
                        state_next = emgtd_pkg::ST_EMIT;
                end
            emgtd_pkg::ST_EMIT:
                if (m_axis_tready)
                begin
                    if (ch_reg == CH_W'(CHANNELS - 1))
                    begin
                        state_next = emgtd_pkg::ST_IDLE;
                        ch_next    = '0;
                    end
                    else
                    begin
                        state_next = emgtd_pkg::ST_DIV;
                        ch_next    = ch_reg + 1'b1;
                    end
                end
            default: state_next = emgtd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= emgtd_pkg::ST_IDLE;
            ch_reg          <= '0;
            feat_reg        <= '0;
            count_reg       <= '0;
            dz_reg          <= 15'd33;
            thr_reg         <= 16'd49;
            div_started_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            feat_reg  <= feat_next;
            if (req.start)
                div_started_reg <= 1'b1;
            else if (div_done)
                div_started_reg <= 1'b0;
            if (clear)
                count_reg <= '0;
            else if (step)
                count_reg <= count_reg + 1'b1;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    emgtd_pkg::REG_DEADZONE: dz_reg  <= cfg_data[14:0];
                    emgtd_pkg::REG_TURN_THR: thr_reg <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            if (feat_reg == 2'd0)
                res_reg[0] <= quot[15:0];
            else
                res_reg[feat_reg] <= (quot > 32'd65535) ? 16'hFFFF : quot[15:0];
        end
    end

    assign s_axis_tready = (state_reg == emgtd_pkg::ST_IDLE);
    assign m_axis_tvalid = (state_reg == emgtd_pkg::ST_EMIT);
    assign m_axis_tdata  = {res_reg[3], res_reg[2], res_reg[1], res_reg[0]};
    assign m_axis_tuser  = 2'(ch_reg);
    assign m_axis_tlast  = (ch_reg == CH_W'(CHANNELS - 1));
endmodule

// ----- hdl/emgtd_checker.sv -----
module emgtd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    // no new samples while results are pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while results pending");

    // closing a window stops input
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input still ready after window close");

    // last result carries the top channel
    a_last_ch: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == 2'd3)
        else $error("last result on wrong channel");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
endmodule

bind emg_time_domain_features_unit emgtd_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
);
